FILE: rtl/id3t_pkg.sv
`default_nettype none
package id3t_pkg;

  // Encoding marker values
  localparam logic [7:0] ENC_LATIN1   = 8'h00;
  localparam logic [7:0] ENC_UTF16    = 8'h01;
  localparam logic [7:0] ENC_UTF16BE  = 8'h02;

  // Byte-order mark halves
  localparam logic [7:0] BOM_FE = 8'hFE;
  localparam logic [7:0] BOM_FF = 8'hFF;

  // Surrogate ranges
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
  localparam logic [15:0] SURR_LO_LAST = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  // UTF-8 lead/continuation marks
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;
  localparam logic [5:0] CONT_MASK = 6'h3F;

  localparam int unsigned JOB_BYTES = 7;

  typedef enum logic [1:0] {
    MODE_LATIN1 = 2'd0,
    MODE_UTF16  = 2'd1,
    MODE_COPY   = 2'd2
  } mode_e;

  // All result bytes caused by one input beat
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      term;
    logic                      trunc;
  } job_t;

  function automatic logic [2:0] cp_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp <= 21'h7F) begin
      len = 3'd1;
    end else if (cp <= 21'h7FF) begin
      len = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Byte 0 goes out first
  function automatic logic [3:0][7:0] utf8_enc(input logic [20:0] cp);
    logic [3:0][7:0] b;
    b = '0;
    unique case (cp_len(cp))
      3'd1: b[0] = cp[7:0];
      3'd2: begin
        b[0] = LEAD2 | {3'b000, cp[10:6]};
        b[1] = CONT | {2'b00, cp[5:0] & CONT_MASK};
      end
      3'd3: begin
        b[0] = LEAD3 | {4'b0000, cp[15:12]};
        b[1] = CONT | {2'b00, cp[11:6] & CONT_MASK};
        b[2] = CONT | {2'b00, cp[5:0] & CONT_MASK};
      end
      default: begin
        b[0] = LEAD4 | {5'b00000, cp[20:18]};
        b[1] = CONT | {2'b00, cp[17:12] & CONT_MASK};
        b[2] = CONT | {2'b00, cp[11:6] & CONT_MASK};
        b[3] = CONT | {2'b00, cp[5:0] & CONT_MASK};
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/id3t_if.sv
`default_nettype none
interface id3t_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        first_byte;
  logic        last_byte;
  logic [12:0] buffer_capacity;

  modport source (output valid, output payload_byte, output first_byte,
                  output last_byte, output buffer_capacity, input ready);
  modport sink   (input valid, input payload_byte, input first_byte,
                  input last_byte, input buffer_capacity, output ready);
endinterface

interface id3t_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       end_of_string;
  logic       truncated;

  modport source (output valid, output utf8_byte, output end_of_string,
                  output truncated, input ready);
  modport sink   (input valid, input utf8_byte, input end_of_string,
                  input truncated, output ready);
endinterface
`default_nettype wire

FILE: rtl/id3_text_to_utf8_transcoder.sv
`default_nettype none
// ID3 text-frame payload to UTF-8 transcoder. Feed one payload byte per beat;
// the beat with first_byte set carries the encoding marker (0 Latin-1, 1 or 2
// UTF-16, anything else copied through) and samples buffer_capacity. The
// block returns UTF-8 bytes one per beat and closes each frame, on the beat
// with last_byte, with a zero byte flagged end_of_string; truncated on that
// beat says capacity cut the text. An input beat is decoded in the cycle it
// is accepted and all the result bytes it causes (zero to seven) land in one
// result register, which then drains one byte per cycle while out_o.ready
// is high. The next input beat is taken as soon as the final byte of the
// previous one leaves. Beats outside a frame are dropped silently.
module id3_text_to_utf8_transcoder #(
  parameter int unsigned MAX_CAPACITY = 4096
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  id3t_in_if.sink   in_i,
  id3t_out_if.source out_o
);

  id3t_pkg::job_t job;
  logic           load;
  logic           take_ok;

  // Decode stage: frame state, surrogate pairing, capacity accounting
  id3t_decode #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .take_ok_i (take_ok),
    .job_o     (job),
    .load_o    (load)
  );

  // Result register: hands out the packed bytes one beat at a time
  id3t_serial u_serial (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .job_i     (job),
    .take_ok_o (take_ok),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire

FILE: rtl/id3t_decode.sv
`default_nettype none
module id3t_decode #(
  parameter int unsigned MAX_CAPACITY = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  id3t_in_if.sink          in_i,
  input  wire logic        take_ok_i,
  output id3t_pkg::job_t   job_o,
  output logic             load_o
);

  localparam int unsigned CW   = $clog2(MAX_CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 13) ? CW : 13;

  id3t_pkg::mode_e mode_q, mode_d;
  logic            be_q, be_d;
  logic            fup_q, fup_d;
  logic            half_q, half_d;
  logic [7:0]      held_q, held_d;
  logic [15:0]     ph_q, ph_d;
  logic            pv_q, pv_d;
  logic [CW-1:0]   used_q, used_d;
  logic [CW-1:0]   cap_q, cap_d;
  logic            full_q, full_d;
  logic            open_q, open_d;

  logic            accept;
  logic            req_a, raw_a, req_b, term;
  logic [20:0]     cp_a, cp_b;
  logic [15:0]     unit;
  logic            bom;
  logic [CMPW-1:0] cap_in;

  assign in_i.ready = take_ok_i;
  assign accept     = in_i.valid && take_ok_i;

  // Capacity intake: zero reads as one, saturate at the maximum
  always_comb begin
    cap_in = CMPW'(in_i.buffer_capacity);
    if (cap_in == '0) begin
      cap_in = CMPW'(1);
    end else if (cap_in > CMPW'(MAX_CAPACITY)) begin
      cap_in = CMPW'(MAX_CAPACITY);
    end
  end

  assign unit = be_q ? {held_q, in_i.payload_byte} : {in_i.payload_byte, held_q};

  // Plan: state update and up to two code points to emit
  always_comb begin
    mode_d = mode_q;
    be_d   = be_q;
    fup_d  = fup_q;
    half_d = half_q;
    held_d = held_q;
    ph_d   = ph_q;
    pv_d   = pv_q;
    cap_d  = cap_q;
    open_d = open_q;
    req_a  = 1'b0;
    raw_a  = 1'b0;
    cp_a   = '0;
    req_b  = 1'b0;
    cp_b   = '0;
    term   = 1'b0;
    bom    = 1'b0;
    if (accept) begin
      if (in_i.first_byte) begin
        if (in_i.payload_byte == id3t_pkg::ENC_LATIN1) begin
          mode_d = id3t_pkg::MODE_LATIN1;
        end else if (in_i.payload_byte == id3t_pkg::ENC_UTF16 ||
                     in_i.payload_byte == id3t_pkg::ENC_UTF16BE) begin
          mode_d = id3t_pkg::MODE_UTF16;
        end else begin
          mode_d = id3t_pkg::MODE_COPY;
        end
        cap_d  = cap_in[CW-1:0];
        be_d   = 1'b1;
        fup_d  = 1'b1;
        half_d = 1'b0;
        held_d = '0;
        ph_d   = '0;
        pv_d   = 1'b0;
        open_d = 1'b1;
      end else if (open_q) begin
        unique case (mode_q)
          id3t_pkg::MODE_LATIN1: begin
            req_a = 1'b1;
            cp_a  = 21'(in_i.payload_byte);
          end
          id3t_pkg::MODE_UTF16: begin
            if (!half_q) begin
              held_d = in_i.payload_byte;
              half_d = 1'b1;
            end else begin
              half_d = 1'b0;
              if (fup_q) begin
                fup_d = 1'b0;
                if (held_q == id3t_pkg::BOM_FE && in_i.payload_byte == id3t_pkg::BOM_FF) begin
                  be_d = 1'b1;
                  bom  = 1'b1;
                end else if (held_q == id3t_pkg::BOM_FF &&
                             in_i.payload_byte == id3t_pkg::BOM_FE) begin
                  be_d = 1'b0;
                  bom  = 1'b1;
                end
              end
              if (!bom) begin
                if (pv_q && unit >= id3t_pkg::SURR_LO_BASE &&
                    unit <= id3t_pkg::SURR_LO_LAST) begin
                  // paired surrogate
                  pv_d  = 1'b0;
                  req_a = 1'b1;
                  cp_a  = id3t_pkg::SUPP_BASE + 21'({ph_q[9:0], unit[9:0]});
                end else begin
                  if (pv_q) begin
                    pv_d  = 1'b0;
                    req_a = 1'b1;
                    cp_a  = 21'(ph_q);
                  end
                  if (unit >= id3t_pkg::SURR_HI_BASE && unit < id3t_pkg::SURR_LO_BASE) begin
                    ph_d = unit;
                    pv_d = 1'b1;
                  end else if (pv_q) begin
                    req_b = 1'b1;
                    cp_b  = 21'(unit);
                  end else begin
                    req_a = 1'b1;
                    cp_a  = 21'(unit);
                  end
                end
              end
            end
          end
          default: begin
            req_a = 1'b1;
            raw_a = 1'b1;
          end
        endcase
      end
      if (in_i.last_byte && (in_i.first_byte || open_q)) begin
        // flush a lone high surrogate before the terminator
        if (mode_d == id3t_pkg::MODE_UTF16 && pv_d) begin
          pv_d = 1'b0;
          if (req_a) begin
            req_b = 1'b1;
            cp_b  = 21'(ph_d);
          end else begin
            req_a = 1'b1;
            cp_a  = 21'(ph_d);
          end
        end
        half_d = 1'b0;
        term   = 1'b1;
        open_d = 1'b0;
      end
    end
  end

  // Emit chain: capacity check for slot A then slot B
  logic [CW-1:0]   lim;
  logic [2:0]      len_a, len_b;
  logic            emit_a, emit_b, full_a, full_b;
  logic [CW:0]     sum_a, sum_b;
  logic [CW-1:0]   used_a, used_b;
  logic [3:0][7:0] enc_a, enc_b;

  assign lim    = cap_q - CW'(1);
  assign len_a  = raw_a ? 3'd1 : id3t_pkg::cp_len(cp_a);
  assign sum_a  = {1'b0, used_q} + (CW+1)'(len_a);
  assign emit_a = req_a && !full_q && (sum_a <= {1'b0, lim});
  assign full_a = full_q || (req_a && !emit_a);
  assign used_a = emit_a ? sum_a[CW-1:0] : used_q;

  assign len_b  = id3t_pkg::cp_len(cp_b);
  assign sum_b  = {1'b0, used_a} + (CW+1)'(len_b);
  assign emit_b = req_b && !full_a && (sum_b <= {1'b0, lim});
  assign full_b = full_a || (req_b && !emit_b);
  assign used_b = emit_b ? sum_b[CW-1:0] : used_a;

  assign enc_a = raw_a ? {24'h0, in_i.payload_byte} : id3t_pkg::utf8_enc(cp_a);
  assign enc_b = id3t_pkg::utf8_enc(cp_b);

  always_comb begin
    if (accept && in_i.first_byte) begin
      used_d = '0;
      full_d = 1'b0;
    end else begin
      used_d = used_b;
      full_d = full_b;
    end
  end

  // Pack A bytes, B bytes, then the terminator
  logic [2:0] n_a, n_b, off;
  logic [3:0] total;

  assign n_a   = emit_a ? len_a : 3'd0;
  assign n_b   = emit_b ? len_b : 3'd0;
  assign total = 4'(n_a) + 4'(n_b) + 4'(term);

  always_comb begin
    job_o.cnt   = total[2:0];
    job_o.term  = term;
    job_o.trunc = term && full_d;
    off         = '0;
    for (int k = 0; k < id3t_pkg::JOB_BYTES; k++) begin
      if (3'(k) < n_a) begin
        job_o.bytes[k] = enc_a[k[1:0]];
      end else if (4'(k) < 4'(n_a) + 4'(n_b)) begin
        off            = 3'(k) - n_a;
        job_o.bytes[k] = enc_b[off[1:0]];
      end else begin
        job_o.bytes[k] = '0;
      end
    end
  end

  assign load_o = accept && (total != 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= id3t_pkg::MODE_LATIN1;
      be_q   <= 1'b1;
      fup_q  <= 1'b1;
      half_q <= 1'b0;
      held_q <= '0;
      ph_q   <= '0;
      pv_q   <= 1'b0;
      used_q <= '0;
      cap_q  <= '0;
      full_q <= 1'b0;
      open_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      be_q   <= be_d;
      fup_q  <= fup_d;
      half_q <= half_d;
      held_q <= held_d;
      ph_q   <= ph_d;
      pv_q   <= pv_d;
      used_q <= used_d;
      cap_q  <= cap_d;
      full_q <= full_d;
      open_q <= open_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/id3t_serial.sv
`default_nettype none
module id3t_serial (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire id3t_pkg::job_t  job_i,
  output logic                 take_ok_o,
  id3t_out_if.source           out_o
);

  id3t_pkg::job_t job_q;
  logic           valid_q, valid_d;
  logic [2:0]     idx_q, idx_d;
  logic           last;

  assign last      = (idx_q == job_q.cnt - 3'd1);
  assign take_ok_o = !valid_q || (out_o.ready && last);

  assign out_o.valid         = valid_q;
  assign out_o.utf8_byte     = job_q.bytes[idx_q];
  assign out_o.end_of_string = job_q.term && last;
  assign out_o.truncated     = job_q.trunc && job_q.term && last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (take_ok_o) begin
      valid_d = load_i;
      idx_d   = '0;
    end else if (out_o.ready) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_ok_o && load_i) begin
      job_q <= job_i;
    end
  end

endmodule
`default_nettype wire
